FILE: design/descending_key_tag_sorter_top_defines.svh
// Assertion macros for the sorter RTL, included by dkts_cells.
// No dependencies; include by bare file name.
`ifndef DESCENDING_KEY_TAG_SORTER_TOP_DEFINES_SVH
`define DESCENDING_KEY_TAG_SORTER_TOP_DEFINES_SVH

// same-cycle implication
`define DKTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DKTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dkts_pkg.sv
// Shared types and constants for the descending key/tag sorter.
// No dependencies.
package dkts_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int TAG_BITS    = 16;
	localparam int KEY_W       = 32;
	localparam int TAG_W       = 16;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic             last;
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage

FILE: design/dkts_queue.sv
// Front end: accepts input transactions and queues them for the sort cells.
// Depends on dkts_pkg.
module dkts_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,   // score_key[31:0], entry_tag[47:32]
	input  logic                 s_tlast,
	output logic                 head_valid,
	output dkts_pkg::entry_t     head,
	input  logic                 pop
);

	localparam int DEPTH = dkts_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	dkts_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             do_pop;
	dkts_pkg::entry_t in_entry;

	always_comb begin
		in_entry.key  = s_tdata[31:0];
		in_entry.tag  = s_tdata[47:32];
		in_entry.last = s_tlast;
	end

	assign s_tready   = (cnt_q != CW'(DEPTH));
	assign push       = s_tvalid && s_tready;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/dkts_cells.sv
// Back end: sorted insertion row of cells, drain sequencer and output register.
// Depends on dkts_pkg and descending_key_tag_sorter_top_defines.svh.
`include "descending_key_tag_sorter_top_defines.svh"

module dkts_cells #(
	parameter int MAX_ITEMS = dkts_pkg::MAX_ITEMS,
	parameter int TAG_BITS  = dkts_pkg::TAG_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dkts_pkg::entry_t e,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,   // sorted_key[31:0], sorted_tag[47:32]
	output logic             m_tlast,
	output logic             m_tuser    // overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int TW = (TAG_BITS < dkts_pkg::TAG_W) ? TAG_BITS : dkts_pkg::TAG_W;
	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                      state_q;
	logic [MAX_ITEMS-1:0]      v_q;
	logic [dkts_pkg::KEY_W-1:0] key_q [MAX_ITEMS];
	logic [TW-1:0]             tag_q [MAX_ITEMS];
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;

	logic [MAX_ITEMS-1:0]      ge;
	logic [MAX_ITEMS-1:0]      take_new;
	logic [dkts_pkg::KEY_W-1:0] dn_key [MAX_ITEMS];
	logic [TW-1:0]             dn_tag [MAX_ITEMS];
	logic [dkts_pkg::KEY_W-1:0] up_key [MAX_ITEMS];
	logic [TW-1:0]             up_tag [MAX_ITEMS];
	logic                      full;
	logic                      ins;
	logic                      shift;
	logic                      run_end;

	logic                      out_valid_q;
	logic [dkts_pkg::KEY_W-1:0] out_key_q;
	logic [TW-1:0]             out_tag_q;
	logic                      out_last_q;
	logic                      out_ovf_q;

	assign full    = (cnt_q == CW'(MAX_ITEMS));
	assign pop     = (state_q == ST_FILL) && in_valid;
	assign ins     = pop && !full;
	assign shift   = (state_q == ST_DRAIN) && (!out_valid_q || m_tready);
	assign run_end = shift && (cnt_q == CW'(1));

	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			ge[i] = v_q[i] && ($signed(key_q[i]) >= $signed(e.key));
		end
		take_new = {ge[MAX_ITEMS-2:0], 1'b1};
		dn_key[0] = e.key;
		dn_tag[0] = e.tag[TW-1:0];
		for (int i = 1; i < MAX_ITEMS; i++) begin
			dn_key[i] = key_q[i-1];
			dn_tag[i] = tag_q[i-1];
		end
		for (int i = 0; i < MAX_ITEMS - 1; i++) begin
			up_key[i] = key_q[i+1];
			up_tag[i] = tag_q[i+1];
		end
		up_key[MAX_ITEMS-1] = key_q[MAX_ITEMS-1];
		up_tag[MAX_ITEMS-1] = tag_q[MAX_ITEMS-1];
	end

	// on insert, cells with a greater-or-equal key hold, the new entry lands in the
	// first cell below them and the rest move down one; on drain every cell moves up one
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (ins && !ge[i]) begin
				if (take_new[i]) begin
					key_q[i] <= e.key;
					tag_q[i] <= e.tag[TW-1:0];
				end else begin
					key_q[i] <= dn_key[i];
					tag_q[i] <= dn_tag[i];
				end
			end else if (shift) begin
				key_q[i] <= up_key[i];
				tag_q[i] <= up_tag[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			v_q     <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (ins) begin
				v_q   <= {v_q[MAX_ITEMS-2:0], 1'b1};
				cnt_q <= cnt_q + 1'b1;
			end else if (shift) begin
				v_q   <= {1'b0, v_q[MAX_ITEMS-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
			if (pop && full) begin
				ovf_q <= 1'b1;
			end else if (run_end) begin
				ovf_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (pop && e.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (run_end) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			out_key_q  <= key_q[0];
			out_tag_q  <= tag_q[0];
			out_last_q <= (cnt_q == CW'(1));
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {dkts_pkg::TAG_W'(out_tag_q), out_key_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	`DKTS_ASSERT_IMP(a_valid_count, 1'b1, $countones(v_q) == 32'(cnt_q), "valid bits disagree with count")
	`DKTS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_ITEMS), "count beyond capacity")
	`DKTS_ASSERT_IMP(a_no_pop_drain, state_q == ST_DRAIN, !pop, "queue popped while draining")
	`DKTS_ASSERT_NXT(a_last_drains, pop && e.last, state_q == ST_DRAIN && cnt_q != '0, "last entry did not start a run")

endmodule

FILE: design/descending_key_tag_sorter_top.sv
// Descending key/tag sorter top level: stream front queue feeding the sort cells.
// Depends on dkts_pkg, dkts_queue and dkts_cells.
//
// Usage:
//   Slave channel (s_*): one transaction per entry; tdata carries the signed
//   Q16.16 score and the tag, tlast marks the final entry of a set.
//   Master channel (m_*): one transaction per held entry, highest score first,
//   equal scores in arrival order; tlast marks the end of the run and tuser
//   is set on every result of a set that overflowed the store.
//   Entries are taken one per cycle while a set fills. After the last entry
//   is accepted and popped into the cell row, the sequencer drains: the run
//   leaves at one result per cycle while m_tready is high, the cell row
//   shifting up one cell into the output register for each result.
//   While a run drains, the four-entry input queue keeps accepting, then
//   s_tready drops until the run is done.
//   Entries beyond MAX_ITEMS in a set are dropped.
//   Reset empties the store, the queue and the output register.
//   A stalled m_tready holds the output register and pauses the drain.
module descending_key_tag_sorter_top #(
	parameter int MAX_ITEMS = dkts_pkg::MAX_ITEMS,
	parameter int TAG_BITS  = dkts_pkg::TAG_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // score_key[31:0], entry_tag[47:32]
	input  logic        s_tlast,   // set_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // sorted_key[31:0], sorted_tag[47:32]
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // overflowed
);

	logic             head_valid;
	dkts_pkg::entry_t head;
	logic             pop;

	dkts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	dkts_cells #(
		.MAX_ITEMS (MAX_ITEMS),
		.TAG_BITS  (TAG_BITS)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (head_valid),
		.e        (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: tb/tb.sv
// Testbench for descending_key_tag_sorter_top: streams sets of score/tag entries,
// predicts each descending run in a local sorted store and checks every result.
// Depends on dkts_pkg and the sorter RTL.
`timescale 1ns / 1ps

module tb;

	localparam int KEY_W        = dkts_pkg::KEY_W;
	localparam int TAG_W        = dkts_pkg::TAG_W;
	localparam int TAG_BITS     = dkts_pkg::TAG_BITS;
	localparam int MAX_ITEMS    = dkts_pkg::MAX_ITEMS;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [TAG_W-1:0] TAG_MASK = (TAG_BITS >= TAG_W) ? '1 :
		TAG_W'((1 << TAG_BITS) - 1);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             drain_first;
	} score_entry_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             run_last;
		logic             overflowed;
	} sorted_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // score_key[31:0], entry_tag[47:32]
	logic        s_tlast = 1'b0; // set_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // sorted_key[31:0], sorted_tag[47:32]
	logic        m_tlast;        // run_last
	logic        m_tuser;        // overflowed

	descending_key_tag_sorter_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// sorted store of the current set, highest score first
	logic [KEY_W-1:0] sort_keys [MAX_ITEMS];
	logic [TAG_W-1:0] sort_tags [MAX_ITEMS];
	int               sort_fill = 0;
	bit               sort_overflow = 1'b0;

	score_entry_t pending_entries[$];
	sorted_pair_t expected_pairs[$];

	int total_items = 0;
	int items_accepted = 0;
	int pairs_predicted = 0;
	int pairs_received = 0;
	int runs_predicted = 0;
	int overflow_runs = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int load_phase();
		if (items_accepted < total_items / 3)
			return 0;
		if (items_accepted < 2 * total_items / 3)
			return 1;
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (load_phase())
			0: return 22;
			1: return 53;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (load_phase())
			0: return 53;
			1: return 22;
			default: return 0;
		endcase
	endfunction

	// insert after every held entry with greater or equal score; emit on last
	task automatic absorb_entry(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic last);
		int pos;
		int k;
		sorted_pair_t pair;
		pos = 0;
		if (sort_fill >= MAX_ITEMS) begin
			sort_overflow = 1'b1;
		end else begin
			while (pos < sort_fill && $signed(sort_keys[pos]) >= $signed(key))
				pos++;
			for (k = sort_fill; k > pos; k--) begin
				sort_keys[k] = sort_keys[k-1];
				sort_tags[k] = sort_tags[k-1];
			end
			sort_keys[pos] = key;
			sort_tags[pos] = tag & TAG_MASK;
			sort_fill++;
		end
		if (last) begin
			for (k = 0; k < sort_fill; k++) begin
				pair.key        = sort_keys[k];
				pair.tag        = sort_tags[k];
				pair.run_last   = (k == sort_fill - 1);
				pair.overflowed = sort_overflow;
				expected_pairs.push_back(pair);
			end
			pairs_predicted <= pairs_predicted + sort_fill;
			runs_predicted++;
			if (sort_overflow)
				overflow_runs++;
			sort_fill = 0;
			sort_overflow = 1'b0;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : sender_proc
		bit           offer;
		bit           drained;
		score_entry_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			drained = (pairs_predicted == pairs_received) && !(s_tvalid && s_tready && s_tlast);
			if (s_tvalid && s_tready) begin
				absorb_entry(s_tdata[31:0], s_tdata[47:32], s_tlast);
				items_accepted <= items_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				offer = 1'b0;
				if (pending_entries.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct())
					offer = !pending_entries[0].drain_first || drained;
				if (offer) begin
					item = pending_entries.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {item.tag, item.key};
					s_tlast <= item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off once the stall-free phase begins
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && load_phase() == 2) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	task automatic report_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// monitor
	always @(posedge clk) begin : monitor_proc
		sorted_pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			pairs_received <= pairs_received + 1;
			if (expected_pairs.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual key %h tag %h",
					$time, m_tdata[31:0], m_tdata[47:32]);
				mismatch_count++;
			end else begin
				want = expected_pairs.pop_front();
				report_field("sorted_key", want.key, m_tdata[31:0]);
				report_field("sorted_tag", 32'(want.tag), 32'(m_tdata[47:32]));
				report_field("run_last", 32'(want.run_last), 32'(m_tlast));
				report_field("overflowed", 32'(want.overflowed), 32'(m_tuser));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_entry(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic last, input logic drain_first);
		score_entry_t item;
		item.key = key;
		item.tag = tag;
		item.last = last;
		item.drain_first = drain_first;
		pending_entries.push_back(item);
	endtask

	function automatic logic [KEY_W-1:0] rand_score();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 6) - 3;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return $urandom & 32'hFFFF_0000;
			default: return $urandom_range(0, 3) << 16;
		endcase
	endfunction

	task automatic push_set(input logic [KEY_W-1:0] keys[$], input int tag_base);
		int i;
		for (i = 0; i < keys.size(); i++)
			push_entry(keys[i], TAG_W'(tag_base + i), i == keys.size() - 1, i == 0);
	endtask

	initial begin : stimulus_proc
		int random_items;
		int set_idx;
		int set_size;
		int i;
		bit drain;
		logic [KEY_W-1:0] keys[$];

		// directed: single-entry runs at the extremes, ties, ordered inputs
		push_entry(32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
		push_entry(32'h8000_0000, 16'h0000, 1'b1, 1'b1);
		keys = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
		push_set(keys, 1);
		keys = '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678};
		push_set(keys, 16'hA0);
		keys = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 32'h1};
		push_set(keys, 16'hFFF0);
		keys = '{32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
		push_set(keys, 16'h5555);

		// random sets; a few fill the store exactly, drop the last entry, or overflow further
		random_items = 0;
		set_idx = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (set_idx)
				6: set_size = MAX_ITEMS;
				16: set_size = MAX_ITEMS + 1;
				26: set_size = $urandom_range(MAX_ITEMS + 2, MAX_ITEMS + 8);
				default: set_size = $urandom_range(1, 12);
			endcase
			drain = ($urandom_range(0, 7) == 0);
			for (i = 0; i < set_size; i++)
				push_entry(rand_score(), TAG_W'($urandom_range(0, 16'hFFFF)),
					i == set_size - 1, drain && i == 0);
			random_items += set_size;
			set_idx++;
		end
		total_items = pending_entries.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < total_items)
			@(posedge clk);
		while (pairs_received != pairs_predicted)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_pairs.size() != 0) begin
			$display("%0t: %0d results still expected, actual none", $time,
				expected_pairs.size());
			mismatch_count++;
		end
		$display("Sent %0d entries forming %0d sorted runs (%0d with dropped entries)",
			total_items, runs_predicted, overflow_runs);
		$display("Checked %0d results under mixed stalls and one long output hold-off",
			pairs_received);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/dkts_pkg.sv
design/dkts_queue.sv
design/dkts_cells.sv
design/descending_key_tag_sorter_top.sv
tb/tb.sv
